/* rtl/pedal_cosine_trajectory_generator_defines.svh */
// assertion helpers for the pedal trajectory rtl, included by pctg_ctrl
`ifndef PEDAL_COSINE_TRAJECTORY_GENERATOR_DEFINES_SVH
`define PEDAL_COSINE_TRAJECTORY_GENERATOR_DEFINES_SVH

// same-cycle implication under reset
`define PCTG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pctg assertion failed");

// next-cycle implication under reset
`define PCTG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pctg assertion failed");

`endif

/* rtl/pctg_pkg.sv */
`default_nettype none

package pctg_pkg;

    // field widths
    localparam int INTERVAL_W = 22;
    localparam int ANGLE_W    = 17;
    localparam int PERIOD_W   = 17;
    localparam int COUNT_W    = 7;
    localparam int NUMBER_W   = 6;
    localparam int FLAGS_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int TERM_W     = 18;
    localparam int PROD_W     = 36;
    localparam int SUM_W      = 20;
    localparam int WIN_W      = 27;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd4;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd5000;

    // timing and scale constants; KICK_SPAN_MAX is kept as 20 * t, SHORT_BEAT_US as plain t in us
    localparam int SHORT_BEAT_US  = 200000;
    localparam int KICK_SPAN_MAX  = 4000000;
    localparam int UNIT_Q15       = 32768;
    localparam int ANGLE_LIMIT    = 36000;

    // segment slots worked per sample
    localparam logic [1:0] SLOT_KL = 2'd0;
    localparam logic [1:0] SLOT_KH = 2'd1;
    localparam logic [1:0] SLOT_HH = 2'd2;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic [1:0] slot;
        logic       div_start;
        logic       mul;
        logic       acc;
        logic       finish;
        logic       next_sample;
    } pctg_cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
        logic slot_use;
        logic div_done;
        logic div_busy;
    } pctg_status_t;

    // round a q16 product half away from zero
    function automatic logic signed [TERM_W-1:0] round16(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] r;
        mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        r   = (mag + PROD_W'(32768)) >> 16;
        return v[PROD_W-1] ? TERM_W'(-$signed(r[TERM_W-1:0])) : $signed(r[TERM_W-1:0]);
    endfunction

    // saturate to the angle range
    function automatic logic signed [ANGLE_W-1:0] clamp_angle(input logic signed [SUM_W-1:0] a);
        if (a > SUM_W'(ANGLE_LIMIT))
            return ANGLE_W'(ANGLE_LIMIT);
        else if (a < -SUM_W'(ANGLE_LIMIT))
            return ANGLE_W'(-ANGLE_LIMIT);
        else
            return a[ANGLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/pctg_beat_if.sv */
`default_nettype none

interface pctg_beat_if;
    logic        valid;
    logic        ready;
    logic [21:0] interval_us;
    logic        kick_now;
    logic        kick_next;
    logic        closed_now;
    logic        closed_next;
    logic [6:0]  point_count;

    modport source (output valid, interval_us, kick_now, kick_next, closed_now,
                    closed_next, point_count, input ready);
    modport sink (input valid, interval_us, kick_now, kick_next, closed_now,
                  closed_next, point_count, output ready);
endinterface

`default_nettype wire

/* rtl/pctg_sample_if.sv */
`default_nettype none

interface pctg_sample_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] kick_angle;
    logic signed [16:0] hat_angle;
    logic [5:0]         sample_number;
    logic               last_point;

    modport source (output valid, kick_angle, hat_angle, sample_number, last_point,
                    input ready);
    modport sink (input valid, kick_angle, hat_angle, sample_number, last_point,
                  output ready);
endinterface

`default_nettype wire

/* rtl/pctg_div.sv */
`default_nettype none

module pctg_div #(
    parameter int NUM_W           = 28,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [NUM_W-1:0] den,
    output logic                  busy,
    output logic                  done,
    output logic [$clog2(2*COS_TABLE_DEPTH)-1:0] quot
);
    localparam int DVW   = NUM_W + $clog2(COS_TABLE_DEPTH + 1);
    localparam int QW    = $clog2(2 * COS_TABLE_DEPTH);
    localparam int CNT_W = $clog2(DVW + 1);
    localparam logic [QW:0] WRAP = (QW + 1)'(2 * COS_TABLE_DEPTH);

    logic [DVW-1:0]   dvd_reg;
    logic [NUM_W-1:0] den_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [QW-1:0]    q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [NUM_W:0]   rem_sh;
    logic [NUM_W-1:0] rem_next;
    logic             bit_q;
    logic [QW:0]      q_sh;
    logic [QW-1:0]    q_next;

    // one restoring step, quotient kept modulo twice the table depth
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[DVW-1]};
        bit_q  = (rem_sh >= {1'b0, den_reg});
        rem_next = bit_q ? NUM_W'(rem_sh - {1'b0, den_reg}) : rem_sh[NUM_W-1:0];
        q_sh = {q_reg, bit_q};
        q_next = (q_sh >= WRAP) ? QW'(q_sh - WRAP) : q_sh[QW-1:0];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= DVW'(num) * DVW'(COS_TABLE_DEPTH);
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVW-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    // zero denominator gives phase zero
    assign quot = (den_reg == '0) ? '0 : q_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* rtl/pctg_cos_rom.sv */
`default_nettype none

module pctg_cos_rom #(
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  wire logic                                    clk,
    input  wire logic [$clog2(COS_TABLE_DEPTH/2+1)-1:0] addr,
    output logic [15:0]                                  data
);
    localparam int HALF = COS_TABLE_DEPTH / 2;

    typedef logic [15:0] rom_arr_t [0:HALF];

    // quarter wave cosine in q15 from a q30 series
    function automatic logic [15:0] cos_quarter(input int j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] p;
        logic [63:0] c;
        x  = (64'(j) * 64'd3373259426) / COS_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        h  = 64'd1073741824 - x2 / 90;
        h  = 64'd1073741824 - ((x2 * h) >> 30) / 56;
        h  = 64'd1073741824 - ((x2 * h) >> 30) / 30;
        h  = 64'd1073741824 - ((x2 * h) >> 30) / 12;
        p  = (x2 * h) >> 31;
        c  = (p >= 64'd1073741824) ? 64'd0 : 64'd1073741824 - p;
        return 16'((c + 64'd16384) >> 15);
    endfunction

    function automatic rom_arr_t build_rom();
        rom_arr_t r;
        for (int j = 0; j <= HALF; j++)
            r[j] = cos_quarter(j);
        return r;
    endfunction

    localparam rom_arr_t COS_ROM = build_rom();

    logic [15:0] data_reg;

    // registered read
    always_ff @(posedge clk)
    begin
        data_reg <= COS_ROM[addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* rtl/pctg_datapath.sv */
`default_nettype none

module pctg_datapath #(
    parameter int MAX_POINTS      = 64,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [pctg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pctg_pkg::ANGLE_W-1:0]       cfg_data,
    input  wire logic [pctg_pkg::INTERVAL_W-1:0]    in_interval,
    input  wire logic [pctg_pkg::FLAGS_W-1:0]       in_flags,
    input  wire logic [pctg_pkg::COUNT_W-1:0]       in_count,
    input  wire pctg_pkg::pctg_cmd_t                cmd,
    output pctg_pkg::pctg_status_t                  status,
    output logic signed [pctg_pkg::ANGLE_W-1:0]     out_kick,
    output logic signed [pctg_pkg::ANGLE_W-1:0]     out_hihat,
    output logic [pctg_pkg::NUMBER_W-1:0]           out_number,
    output logic                                    out_last
);
    import pctg_pkg::*;

    localparam int TW   = $clog2(MAX_POINTS) + 22;
    localparam int NW   = (TW > WIN_W) ? TW : WIN_W;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int QW   = $clog2(2 * COS_TABLE_DEPTH);
    localparam int AW   = $clog2(COS_TABLE_DEPTH / 2 + 1);
    localparam int STEP_W = 22;

    // configuration
    logic signed [ANGLE_W-1:0] ready_reg, press_reg, open_reg, closed_reg;
    logic [PERIOD_W-1:0]       period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg  <= '0;
            press_reg  <= '0;
            open_reg   <= '0;
            closed_reg <= '0;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_READY:  ready_reg  <= cfg_data;
                CFG_PRESS:  press_reg  <= cfg_data;
                CFG_OPEN:   open_reg   <= cfg_data;
                CFG_CLOSED: closed_reg <= cfg_data;
                CFG_PERIOD: period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // beat state and sample position
    logic [INTERVAL_W-1:0] t_reg;
    logic [FLAGS_W-1:0]    flags_reg;
    logic [CW-1:0]         n_reg;
    logic [IW-1:0]         idx_reg;
    logic [TW-1:0]         t20_reg;
    logic [STEP_W-1:0]     step;

    assign step = (STEP_W'(period_reg) << 4) + (STEP_W'(period_reg) << 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg     <= '0;
            flags_reg <= '0;
            n_reg     <= '0;
            idx_reg   <= '0;
            t20_reg   <= '0;
        end
        else if (cmd.load)
        begin
            t_reg     <= in_interval;
            flags_reg <= in_flags;
            n_reg     <= (in_count > COUNT_W'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(in_count);
            idx_reg   <= '0;
            t20_reg   <= '0;
        end
        else if (cmd.next_sample)
        begin
            idx_reg <= idx_reg + IW'(1);
            t20_reg <= t20_reg + TW'(step);
        end
    end

    // windows of the held beat, all scaled by 20
    logic [NW-1:0] tn, eight_c, span_c;
    logic [NW-1:0] beat_reg, half_reg, stay_reg, lift_reg, span_reg;
    logic [NW-1:0] two_reg, settle_reg, sixteen_reg;
    logic          short_reg;

    assign tn      = NW'(t_reg);
    assign eight_c = tn << 3;
    assign span_c  = (eight_c < NW'(KICK_SPAN_MAX)) ? eight_c : NW'(KICK_SPAN_MAX);

    always_ff @(posedge clk)
    begin
        beat_reg    <= (tn << 4) + (tn << 2);
        half_reg    <= (tn << 3) + (tn << 1);
        stay_reg    <= (tn << 3) + tn;
        span_reg    <= span_c;
        lift_reg    <= (tn << 4) + (tn << 2) - span_c;
        two_reg     <= tn << 1;
        settle_reg  <= (tn << 4) + (tn << 1);
        sixteen_reg <= tn << 4;
        short_reg   <= (t_reg <= INTERVAL_W'(SHORT_BEAT_US));
    end

    // segment selection for the current slot
    logic          kn, kx, cn, cx;
    logic [NW-1:0] tt, num_c, den_c;
    logic          use_c, off_c, hh_window;

    assign kn = flags_reg[3];
    assign kx = flags_reg[2];
    assign cn = flags_reg[1];
    assign cx = flags_reg[0];
    assign tt = NW'(t20_reg);
    assign hh_window = short_reg || (tt >= two_reg && tt < settle_reg);

    always_comb
    begin
        use_c = 1'b0;
        num_c = tt;
        den_c = beat_reg;
        off_c = 1'b0;
        case (cmd.slot)
            SLOT_KL:
            begin
                off_c = 1'b1;
                if (short_reg)
                    use_c = kn;
                else
                begin
                    use_c = kn && (tt < stay_reg);
                    den_c = stay_reg;
                end
            end
            SLOT_KH:
            begin
                if (short_reg)
                begin
                    if (kn && kx)
                    begin
                        use_c = (tt >= half_reg);
                        num_c = tt - half_reg;
                        den_c = half_reg;
                    end
                    else
                        use_c = kx;
                end
                else
                begin
                    use_c = kx && (tt > lift_reg) && (tt <= beat_reg);
                    num_c = tt - lift_reg;
                    den_c = span_reg;
                end
            end
            default:
            begin
                use_c = (cn ^ cx) && hh_window;
                if (!short_reg)
                begin
                    num_c = tt - two_reg;
                    den_c = sixteen_reg;
                end
            end
        endcase
    end

    // phase divider
    logic [QW-1:0] quot;
    logic          div_busy, div_done;

    pctg_div #(
        .NUM_W           (NW),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_c),
        .den   (den_c),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (quot)
    );

    // fold the phase onto the quarter wave
    logic [QW:0]   k0;
    logic [QW-1:0] k1;
    logic          neg_c;
    logic [AW-1:0] rom_addr;

    always_comb
    begin
        k0 = (QW + 1)'(quot) + (off_c ? (QW + 1)'(COS_TABLE_DEPTH) : '0);
        if (k0 >= (QW + 1)'(2 * COS_TABLE_DEPTH))
            k0 = k0 - (QW + 1)'(2 * COS_TABLE_DEPTH);
        k1 = k0[QW-1:0];
        neg_c = 1'b0;
        if (k1 >= QW'(COS_TABLE_DEPTH))
        begin
            k1 = k1 - QW'(COS_TABLE_DEPTH);
            neg_c = 1'b1;
        end
        if ((QW + 1)'(k1) * 2 > (QW + 1)'(COS_TABLE_DEPTH))
        begin
            k1 = QW'(COS_TABLE_DEPTH) - k1;
            neg_c = !neg_c;
        end
        rom_addr = AW'(k1);
    end

    logic [15:0] rom_data;
    logic        neg_reg;

    pctg_cos_rom #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_c;
    end

    // scaled segment product
    logic signed [ANGLE_W-1:0] c_val;
    logic signed [TERM_W-1:0]  factor, mcand, d_kick, d_hh;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      is_hh;

    assign is_hh  = (cmd.slot == SLOT_HH);
    assign c_val  = neg_reg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
    assign d_kick = TERM_W'(press_reg) - TERM_W'(ready_reg);
    assign d_hh   = (cn && !cx) ? (TERM_W'(closed_reg) - TERM_W'(open_reg))
                                : (TERM_W'(open_reg) - TERM_W'(closed_reg));
    assign factor = is_hh ? (TERM_W'(UNIT_Q15) + TERM_W'(c_val))
                          : (TERM_W'(UNIT_Q15) - TERM_W'(c_val));
    assign mcand  = is_hh ? d_hh : d_kick;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= mcand * factor;
    end

    // segment terms
    logic signed [TERM_W-1:0] xl_reg, xh_reg, hh_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            xl_reg <= '0;
            xh_reg <= '0;
            hh_reg <= '0;
        end
        else if (cmd.acc)
        begin
            case (cmd.slot)
                SLOT_KL: xl_reg <= round16(prod_reg);
                SLOT_KH: xh_reg <= round16(prod_reg);
                default: hh_reg <= round16(prod_reg);
            endcase
        end
    end

    // final angles
    logic signed [SUM_W-1:0] kick_sum, hh_sum;

    assign kick_sum = SUM_W'(ready_reg) + SUM_W'(xl_reg) + SUM_W'(xh_reg);

    always_comb
    begin
        if (!cn && !cx)
            hh_sum = SUM_W'(open_reg);
        else if (!short_reg && tt < two_reg)
            hh_sum = cn ? SUM_W'(closed_reg) : SUM_W'(open_reg);
        else if (!short_reg && tt >= settle_reg)
            hh_sum = cx ? SUM_W'(closed_reg) : SUM_W'(open_reg);
        else if (cn && !cx)
            hh_sum = SUM_W'(open_reg) + SUM_W'(hh_reg);
        else if (cx && !cn)
            hh_sum = SUM_W'(closed_reg) + SUM_W'(hh_reg);
        else
            hh_sum = SUM_W'(closed_reg);
    end

    logic signed [ANGLE_W-1:0] kick_out_reg, hihat_out_reg;
    logic [NUMBER_W-1:0]       number_reg;
    logic                      last_reg;
    logic                      last_c;

    assign last_c = ((CW + 1)'(idx_reg) + (CW + 1)'(1) == (CW + 1)'(n_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            kick_out_reg  <= clamp_angle(kick_sum);
            hihat_out_reg <= clamp_angle(hh_sum);
            number_reg    <= NUMBER_W'(idx_reg);
            last_reg      <= last_c;
        end
    end

    assign out_kick   = kick_out_reg;
    assign out_hihat  = hihat_out_reg;
    assign out_number = number_reg;
    assign out_last   = last_reg;

    assign status.empty    = (n_reg == '0);
    assign status.last     = last_c;
    assign status.slot_use = use_c;
    assign status.div_done = div_done;
    assign status.div_busy = div_busy;

endmodule

`default_nettype wire

/* rtl/pctg_ctrl.sv */
`default_nettype none
`include "pedal_cosine_trajectory_generator_defines.svh"

module pctg_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   beat_valid,
    output logic                        beat_ready,
    output logic                        sample_valid,
    input  wire logic                   sample_ready,
    input  wire pctg_pkg::pctg_status_t status,
    output pctg_pkg::pctg_cmd_t         cmd
);
    import pctg_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_SLOT  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_ROM   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] slot_reg, slot_next;

    // sequencing of slots and samples
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        cmd.slot   = slot_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (beat_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.empty)
                    state_next = S_IDLE;
                else
                begin
                    cmd.clear  = 1'b1;
                    slot_next  = SLOT_KL;
                    state_next = S_SLOT;
                end
            end
            S_SLOT:
            begin
                if (status.slot_use)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (slot_reg == SLOT_HH)
                    state_next = S_FIN;
                else
                    slot_next = slot_reg + 2'd1;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_ROM;
            end
            S_ROM:
                state_next = S_MUL;
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (slot_reg == SLOT_HH)
                    state_next = S_FIN;
                else
                begin
                    slot_next  = slot_reg + 2'd1;
                    state_next = S_SLOT;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sample_ready)
                begin
                    if (status.last)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.next_sample = 1'b1;
                        state_next      = S_CHECK;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= SLOT_KL;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    assign beat_ready   = (state_reg == S_IDLE);
    assign sample_valid = (state_reg == S_OUT);

    // checks
    `PCTG_ASSERT_IMP(a_out_nonempty, clk, rst_n, state_reg == S_OUT, !status.empty)
    `PCTG_ASSERT_IMP(a_idle_div_quiet, clk, rst_n, state_reg == S_IDLE, !status.div_busy)
    `PCTG_ASSERT_NXT(a_div_to_rom, clk, rst_n, state_reg == S_DIV && status.div_done, state_reg == S_ROM)
    `PCTG_ASSERT_IMP(a_done_used, clk, rst_n, state_reg == S_DIV && status.div_done, status.slot_use)

endmodule

`default_nettype wire

/* rtl/pedal_cosine_trajectory_generator.sv */
`default_nettype none
// Pedal cosine trajectory generator.
// beat channel: one request per beat (interval_us, kick/closed flags for this
// and the next beat, point_count). sample channel: point_count requests, capped
// at MAX_POINTS, each with kick and hi-hat angles in centidegrees, the sample
// number and a last_point mark. a beat with zero points gives no samples.
// configuration: cfg_wr_en, cfg_index, cfg_data write one register per cycle
// (rest, pressed, open, closed angles and the sample period); write only idle.
// sequencing: each sample works up to three segments; every used segment
// starts the divider, runs 39 restoring steps (one per dividend bit at the
// default sizes), takes the done strobe, then does the cosine table read,
// multiply and rounding. an unused segment is skipped. one beat is worked at
// a time; beat.ready is high only when the previous beat is fully delivered.
// stall: a sample waits in the output registers while sample.ready is low and
// no further work is done until it is taken.
// reset: registers return to zero angles and a 5000 us period, any beat in
// progress is dropped.
module pedal_cosine_trajectory_generator #(
    parameter int MAX_POINTS      = 64,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pctg_beat_if.sink                            beat,
    pctg_sample_if.source                        sample,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pctg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pctg_pkg::ANGLE_W-1:0]    cfg_data
);
    import pctg_pkg::*;

    pctg_cmd_t    cmd;
    pctg_status_t status;

    pctg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .beat_valid   (beat.valid),
        .beat_ready   (beat.ready),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .status       (status),
        .cmd          (cmd)
    );

    pctg_datapath #(
        .MAX_POINTS      (MAX_POINTS),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_interval (beat.interval_us),
        .in_flags    ({beat.kick_now, beat.kick_next, beat.closed_now, beat.closed_next}),
        .in_count    (beat.point_count),
        .cmd         (cmd),
        .status      (status),
        .out_kick    (sample.kick_angle),
        .out_hihat   (sample.hat_angle),
        .out_number  (sample.sample_number),
        .out_last    (sample.last_point)
    );

endmodule

`default_nettype wire

/* tb/pctg_sample_checker.sv */
`timescale 1ns / 100ps

module pctg_sample_checker #(
    parameter int MAX_POINTS      = 64,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    pctg_beat_if                           beat,
    pctg_sample_if                         sample,
    input  logic                           cfg_wr_en,
    input  logic [pctg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pctg_pkg::ANGLE_W-1:0]   cfg_data,
    output int                             fail_count,
    output int                             pending
);
    import pctg_pkg::*;

    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned DEPTH   = COS_TABLE_DEPTH;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] kick_angle;
        logic signed [ANGLE_W-1:0] hat_angle;
        logic [NUMBER_W-1:0]       sample_number;
        logic                      last_point;
    } pedal_sample_t;

    pedal_sample_t             sample_queue[$];
    logic signed [ANGLE_W-1:0] rest_angle, pressed_angle, hat_open, hat_closed;
    logic [PERIOD_W-1:0]       step_us;

    assign pending = sample_queue.size();

    // quarter-wave cosine in q15 from the series polynomial
    function automatic longint cos_quarter(longint unsigned j);
        longint unsigned x, x2, h, p, c;
        x  = j * PI_Q30 / DEPTH;
        x2 = (x * x) >> 30;
        h  = ONE_Q30 - x2 / 90;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 56;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 30;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 12;
        p  = (x2 * h) >> 31;
        c  = (p >= ONE_Q30) ? 0 : ONE_Q30 - p;
        return longint'((c + 16384) >> 15);
    endfunction

    function automatic longint cos_wave(longint unsigned k);
        bit     neg;
        longint v;
        neg = 0;
        k   = k % (2 * DEPTH);
        if (k >= DEPTH)
        begin
            k   = k - DEPTH;
            neg = !neg;
        end
        if (2 * k > DEPTH)
        begin
            k   = DEPTH - k;
            neg = !neg;
        end
        v = cos_quarter(k);
        return neg ? -v : v;
    endfunction

    function automatic longint unsigned phase_idx(longint unsigned num, longint unsigned den);
        if (den == 0)
            return 0;
        return (num * DEPTH / den) % (2 * DEPTH);
    endfunction

    // half away from zero
    function automatic longint round_q16(longint v);
        if (v >= 0)
            return (v + 32768) >>> 16;
        return -((-v + 32768) >>> 16);
    endfunction

    function automatic longint press_term(longint d, longint unsigned k);
        return round_q16(d * (UNIT_Q15 - cos_wave(k)));
    endfunction

    function automatic longint hat_blend(longint qi, longint qf, longint unsigned k);
        return qf + round_q16((qi - qf) * (UNIT_Q15 + cos_wave(k)));
    endfunction

    function automatic logic signed [ANGLE_W-1:0] saturate(longint a);
        if (a > ANGLE_LIMIT)
            return ANGLE_W'(ANGLE_LIMIT);
        if (a < -ANGLE_LIMIT)
            return ANGLE_W'(-ANGLE_LIMIT);
        return ANGLE_W'(a);
    endfunction

    function automatic logic signed [ANGLE_W-1:0] kick_at(longint unsigned t20,
            longint unsigned span, bit now, bit next);
        longint          d, xl, xh;
        longint unsigned whole, stay, lift;
        d     = longint'(pressed_angle) - longint'(rest_angle);
        xl    = 0;
        xh    = 0;
        whole = 20 * span;
        if (span <= SHORT_BEAT_US)
        begin
            if (now)
                xl = press_term(d, phase_idx(t20, whole) + DEPTH);
            if (next && now)
            begin
                if (t20 >= 10 * span)
                    xh = press_term(d, phase_idx(t20 - 10 * span, 10 * span));
            end
            else if (next)
                xh = press_term(d, phase_idx(t20, whole));
        end
        else
        begin
            stay = 9 * span;
            lift = 12 * span;
            if (whole - KICK_SPAN_MAX > lift)
                lift = whole - KICK_SPAN_MAX;
            if (t20 < stay)
            begin
                if (now)
                    xl = press_term(d, phase_idx(t20, stay) + DEPTH);
            end
            else if (t20 > lift && t20 <= whole)
            begin
                if (next)
                    xh = press_term(d, phase_idx(t20 - lift, whole - lift));
            end
        end
        return saturate(longint'(rest_angle) + xl + xh);
    endfunction

    function automatic logic signed [ANGLE_W-1:0] hihat_at(longint unsigned t20,
            longint unsigned span, bit now, bit next);
        longint          a, qo, qc;
        longint unsigned lift, settle, k;
        qo = longint'(hat_open);
        qc = longint'(hat_closed);
        if (!now && !next)
            a = qo;
        else if (span <= SHORT_BEAT_US)
        begin
            if (now && !next)
                a = hat_blend(qc, qo, phase_idx(t20, 20 * span));
            else if (next && !now)
                a = hat_blend(qo, qc, phase_idx(t20, 20 * span));
            else
                a = qc;
        end
        else
        begin
            lift   = 2 * span;
            settle = 18 * span;
            if (t20 < lift)
                a = now ? qc : qo;
            else if (t20 < settle)
            begin
                k = phase_idx(t20 - lift, settle - lift);
                if (now && !next)
                    a = hat_blend(qc, qo, k);
                else if (next && !now)
                    a = hat_blend(qo, qc, k);
                else
                    a = qc;
            end
            else
                a = next ? qc : qo;
        end
        return saturate(a);
    endfunction

    // register mirror, beat prediction and sample comparison
    always @(posedge clk or negedge rst_n)
    begin
        pedal_sample_t   want, got;
        longint unsigned n, t20;
        if (!rst_n)
        begin
            rest_angle    <= '0;
            pressed_angle <= '0;
            hat_open      <= '0;
            hat_closed    <= '0;
            step_us       <= PERIOD_RESET;
            fail_count    <= 0;
            sample_queue.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_READY:  rest_angle    <= cfg_data;
                    CFG_PRESS:  pressed_angle <= cfg_data;
                    CFG_OPEN:   hat_open      <= cfg_data;
                    CFG_CLOSED: hat_closed    <= cfg_data;
                    CFG_PERIOD: step_us       <= cfg_data;
                    default: ;
                endcase
            end

            // new beat request
            if (beat.valid && beat.ready)
            begin
                n = (beat.point_count > MAX_POINTS) ? MAX_POINTS : beat.point_count;
                for (longint unsigned i = 0; i < n; i++)
                begin
                    t20 = 20 * i * step_us;
                    want.kick_angle    = kick_at(t20, beat.interval_us, beat.kick_now,
                                                 beat.kick_next);
                    want.hat_angle     = hihat_at(t20, beat.interval_us, beat.closed_now,
                                                  beat.closed_next);
                    want.sample_number = NUMBER_W'(i);
                    want.last_point    = (i + 1 == n);
                    sample_queue.push_back(want);
                end
            end

            // sample request
            if (sample.valid && sample.ready)
            begin
                got.kick_angle    = sample.kick_angle;
                got.hat_angle     = sample.hat_angle;
                got.sample_number = sample.sample_number;
                got.last_point    = sample.last_point;
                if (sample_queue.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected sample: kick %0d hihat %0d number %0d last %0b",
                                 got.kick_angle, got.hat_angle, got.sample_number,
                                 got.last_point);
                end
                else
                begin
                    want = sample_queue.pop_front();
                    if (want != got)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected kick %0d hihat %0d number %0d",
                                     want.kick_angle, want.hat_angle, want.sample_number,
                                     " last %0b, got kick %0d hihat %0d number %0d",
                                     want.last_point, got.kick_angle, got.hat_angle,
                                     got.sample_number, " last %0b", got.last_point);
                    end
                end
            end
        end
    end

endmodule

/* tb/pedal_cosine_trajectory_generator_test.sv */
`timescale 1ns / 100ps

module pedal_cosine_trajectory_generator_test;
    import pctg_pkg::*;

    localparam longint CYCLE_LIMIT = 20000000;
    localparam int     BEATS_PER_PHASE = 34;
    localparam int     PHASES = 6;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ANGLE_W-1:0]   cfg_data;
    int                   fail_count;
    int                   pending;
    longint               cycles;
    bit                   beat_gaps;
    bit                   sample_stalls;

    pctg_beat_if   beat ();
    pctg_sample_if sample ();

    pedal_cosine_trajectory_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .sample    (sample),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pctg_sample_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .sample     (sample),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // sample side back-pressure
    initial
    begin
        int n;
        sample.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = sample_stalls ? $urandom_range(0, 16) : 0;
            if (n > 0)
            begin
                sample.ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            sample.ready = 1'b1;
            do @(posedge clk); while (!sample.valid);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic load_setting(input int rest, input int pressed, input int hopen,
                                input int hclosed, input int period);
        write_reg(CFG_READY, ANGLE_W'(rest));
        write_reg(CFG_PRESS, ANGLE_W'(pressed));
        write_reg(CFG_OPEN, ANGLE_W'(hopen));
        write_reg(CFG_CLOSED, ANGLE_W'(hclosed));
        write_reg(CFG_PERIOD, ANGLE_W'(period));
    endtask

    // wait for every sample, then let a trailing zero-point beat finish
    task automatic drain_samples();
        beat.valid = 1'b0;
        wait (pending == 0);
        repeat (300) @(negedge clk);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_beat(input logic [21:0] span, input logic [3:0] flags,
                             input logic [6:0] count);
        int gap;
        gap = beat_gaps ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            beat.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        beat.valid       = 1'b1;
        beat.interval_us = span;
        beat.kick_now    = flags[3];
        beat.kick_next   = flags[2];
        beat.closed_now  = flags[1];
        beat.closed_next = flags[0];
        beat.point_count = count;
        do @(posedge clk); while (!beat.ready);
        @(negedge clk);
    endtask

    task automatic send_random_beat();
        logic [21:0] span;
        logic [6:0]  count;
        int          sel;
        int          pick;
        sel = $urandom_range(0, 9);
        if (sel <= 3)
            span = 22'($urandom_range(1, 200000));
        else if (sel <= 6)
            span = 22'($urandom_range(200001, 4000000));
        else if (sel == 7)
            span = 22'($urandom);
        else if (sel == 8)
        begin
            pick = $urandom_range(0, 5);
            case (pick)
                0: span = 22'd0;
                1: span = 22'd1;
                2: span = 22'd200000;
                3: span = 22'd200001;
                4: span = 22'd4000000;
                default: span = 22'h3FFFFF;
            endcase
        end
        else
            span = 22'($urandom_range(0, 2000));
        pick = $urandom_range(0, 99);
        if (pick < 85)
            count = 7'($urandom_range(1, 12));
        else if (pick < 90)
            count = 7'd0;
        else if (pick < 95)
            count = 7'd64;
        else
            count = 7'($urandom_range(13, 127));
        send_beat(span, 4'($urandom_range(0, 15)), count);
    endtask

    // stimulus and verdict
    initial
    begin
        int rest, pressed, hopen, hclosed, period;
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        beat.valid       = 1'b0;
        beat.interval_us = '0;
        beat.kick_now    = 1'b0;
        beat.kick_next   = 1'b0;
        beat.closed_now  = 1'b0;
        beat.closed_next = 1'b0;
        beat.point_count = '0;
        beat_gaps        = 1'b0;
        sample_stalls    = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: extreme angles so segment sums saturate
        load_setting(-36000, 36000, 36000, -36000, 5000);
        for (int f = 0; f < 16; f++)
            send_beat(22'd100000, 4'(f), 7'd24);
        beat_gaps     = 1'b1;
        sample_stalls = 1'b1;
        send_beat(22'd0, 4'b1111, 7'd3);
        send_beat(22'd200000, 4'b1010, 7'd1);
        send_beat(22'd200001, 4'b0101, 7'd0);
        send_beat(22'd4000000, 4'b1111, 7'd64);
        send_beat(22'h3FFFFF, 4'b0110, 7'd127);
        send_beat(22'd150000, 4'b1100, 7'd40);
        drain_samples();

        // directed: zero sample period
        load_setting(36000, -36000, -36000, 36000, 0);
        send_beat(22'd500000, 4'b1001, 7'd5);
        send_beat(22'd50000, 4'b0110, 7'd5);
        drain_samples();

        // random phases, each from an idle block with fresh registers
        for (int ph = 0; ph < PHASES; ph++)
        begin
            rest    = $urandom_range(0, 72000) - 36000;
            pressed = $urandom_range(0, 72000) - 36000;
            hopen   = $urandom_range(0, 72000) - 36000;
            hclosed = $urandom_range(0, 72000) - 36000;
            case (ph)
                0: period = 1;
                1: period = 100000;
                2: period = 17'h1FFFF;
                default: period = $urandom_range(1, 100000);
            endcase
            if (ph == 1)
                load_setting(36000, -36000, -36000, 36000, period);
            else
                load_setting(rest, pressed, hopen, hclosed, period);
            for (int b = 0; b < BEATS_PER_PHASE; b++)
            begin
                if (b % 10 == 0)
                begin
                    beat_gaps     = $urandom_range(0, 2) != 0;
                    sample_stalls = $urandom_range(0, 2) != 0;
                end
                send_random_beat();
            end
            drain_samples();
        end

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
